/* design/smtg_pkg.sv */
// Package: shared types, codes and helpers of the stencil matrix triplet generator.
package smtg_pkg;

    // Request codes carried in req_type
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE_TWO_DIM    = 3'd0;
    localparam logic [2:0] CFG_GRID_ROWS       = 3'd1;
    localparam logic [2:0] CFG_GRID_COLS       = 3'd2;
    localparam logic [2:0] CFG_STENCIL_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_EKIN_SCALE      = 3'd4;
    localparam logic [2:0] CFG_COEFF_THRESHOLD = 3'd5;

    // Command field widths, sized for the largest supported stencil (7 x 7)
    localparam int OFF_W      = 4;
    localparam int SLOT_CMD_W = 6;

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DRAIN
    } ctl_state_t;

    typedef struct packed {
        logic               mode_two_dim;
        logic [10:0]        grid_rows;
        logic [10:0]        grid_cols;
        logic [2:0]         stencil_width;
        logic signed [31:0] ekin_scale;
        logic [30:0]        coeff_threshold;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic                    load_coeff;
        logic                    load_point;
        logic                    issue;
        logic                    flush;
        logic [SLOT_CMD_W-1:0]   slot;
        logic signed [OFF_W-1:0] dx;
        logic signed [OFF_W-1:0] dy;
        logic                    diag;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic adv;
        logic point_ok;
        logic flush_done;
    } dp_status_t;

    // Zero counts as one, anything above the limit saturates to it
    function automatic logic [10:0] clamp_grid(input logic [10:0] g, input int max_grid);
        logic [10:0] r;
        if (g == 11'd0)
            r = 11'd1;
        else if (int'(g) > max_grid)
            r = 11'(max_grid);
        else
            r = g;
        return r;
    endfunction

endpackage

/* design/smtg_if.sv */
// Interfaces: request and triplet channels with valid/ready handshake.
interface smtg_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [4:0]         coeff_slot;
    logic signed [31:0] coeff_value;
    logic [9:0]         point_row;
    logic [9:0]         point_col;
    logic signed [31:0] potential;

    modport source (
        output valid, req_type, coeff_slot, coeff_value, point_row, point_col, potential,
        input  ready
    );
    modport sink (
        input  valid, req_type, coeff_slot, coeff_value, point_row, point_col, potential,
        output ready
    );
endinterface

interface smtg_trip_if;
    logic               valid;
    logic               ready;
    logic [19:0]        matrix_row;
    logic [19:0]        matrix_col;
    logic signed [31:0] entry_value;
    logic               last_of_point;

    modport source (
        output valid, matrix_row, matrix_col, entry_value, last_of_point,
        input  ready
    );
    modport sink (
        input  valid, matrix_row, matrix_col, entry_value, last_of_point,
        output ready
    );
endinterface

/* design/smtg_ctrl.sv */
// Controller: request sequencing and stencil offset walk.
module smtg_ctrl
    import smtg_pkg::*;
#(
    parameter int MAX_STENCIL = 5
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    input  logic       in_req_type,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam int DEPTH  = MAX_STENCIL * MAX_STENCIL;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW     = $clog2(MAX_STENCIL + 1);

    ctl_state_t        state_reg, state_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [XW-1:0]     y_reg, y_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic [XW-1:0] w_clamp;
    logic [XW-1:0] w_eff;
    logic [XW-1:0] half;
    logic [XW-1:0] y_lim;
    logic [XW-1:0] y_half;
    logic          last_step;

    // Clamp to [1, MAX_STENCIL], then drop an even width by one
    always_comb
    begin
        if (cfg.stencil_width == 3'd0)
            w_clamp = XW'(1);
        else if (int'(cfg.stencil_width) > MAX_STENCIL)
            w_clamp = XW'(MAX_STENCIL);
        else
            w_clamp = XW'(cfg.stencil_width);
        w_eff = w_clamp[0] ? w_clamp : (w_clamp - XW'(1));
    end

    assign half      = w_eff >> 1;
    assign y_lim     = cfg.mode_two_dim ? w_eff : XW'(1);
    assign y_half    = cfg.mode_two_dim ? half : '0;
    assign last_step = (x_reg == w_eff - XW'(1)) && (y_reg == y_lim - XW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        slot_next      = slot_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.slot       = SLOT_CMD_W'(slot_reg);
        cmd.dx         = OFF_W'(x_reg) - OFF_W'(half);
        cmd.dy         = OFF_W'(y_reg) - OFF_W'(y_half);
        cmd.diag       = (cmd.dx == '0) && (cmd.dy == '0);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_req_type == REQ_LOAD)
                        cmd.load_coeff = 1'b1;
                    else if (status.point_ok)
                    begin
                        cmd.load_point = 1'b1;
                        x_next         = '0;
                        y_next         = '0;
                        slot_next      = '0;
                        state_next     = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (status.adv)
                begin
                    cmd.issue = 1'b1;
                    slot_next = slot_reg + SLOT_W'(1);
                    if (last_step)
                        state_next = ST_FLUSH;
                    else if (y_reg == y_lim - XW'(1))
                    begin
                        y_next = '0;
                        x_next = x_reg + XW'(1);
                    end
                    else
                        y_next = y_reg + XW'(1);
                end
            end
            ST_FLUSH:
            begin
                if (status.adv)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.flush_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/smtg_dp.sv */
// Datapath: coefficient store, offset pipeline, scaling, saturation and output stage.
module smtg_dp
    import smtg_pkg::*;
#(
    parameter int MAX_STENCIL = 5,
    parameter int MAX_GRID    = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  ctl_cmd_t           cmd,
    output dp_status_t         status,
    input  logic [4:0]         coeff_slot,
    input  logic signed [31:0] coeff_value,
    input  logic [9:0]         point_row,
    input  logic [9:0]         point_col,
    input  logic signed [31:0] potential,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [19:0]        matrix_row,
    output logic [19:0]        matrix_col,
    output logic signed [31:0] entry_value,
    output logic               last_of_point
);

    localparam int DEPTH  = MAX_STENCIL * MAX_STENCIL;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] store_mem [DEPTH];
    logic [31:0] rd_reg;

    logic [10:0] rows_eff;
    logic [10:0] cols_eff;
    logic [9:0]  col_in;
    logic [20:0] row_prod;
    logic [21:0] row_flat_n;
    logic        adv;

    // Point held for the walk
    logic [9:0]         row_reg;
    logic [9:0]         col_reg;
    logic signed [31:0] pot_reg;
    logic [19:0]        row_flat_reg;

    // Issue stage
    logic signed [11:0] ri_n, ci_n;
    logic               inb_n;
    logic        a_valid_reg, a_flush_reg;
    logic        a_inb_reg, a_diag_reg;
    logic [10:0] a_ri_reg, a_ci_reg;

    // Product stage
    logic signed [31:0] coeff_b;
    logic [31:0]        mag_b;
    logic               big_b;
    logic signed [63:0] prod_b;
    logic [22:0]        col_flat_b;
    logic               b_valid_reg, b_flush_reg, b_keep_reg, b_use_reg, b_diag_reg;
    logic signed [63:0] b_prod_reg;
    logic [19:0]        b_cf_reg;

    // Rounding stage
    logic signed [63:0] rnd_c;
    logic signed [63:0] sh_full_c;
    logic               c_valid_reg, c_flush_reg, c_keep_reg, c_diag_reg;
    logic signed [47:0] c_sh_reg;
    logic [19:0]        c_cf_reg;

    // Potential add and saturation
    logic signed [48:0] sum_d;
    logic signed [31:0] cand_d;

    // One-deep hold so the last triplet of a point can be marked
    logic               pend_valid_reg;
    logic [19:0]        pend_cf_reg;
    logic signed [31:0] pend_val_reg;
    logic [19:0]        pend_row_reg;

    logic               out_valid_reg;
    logic [19:0]        out_row_reg, out_col_reg;
    logic signed [31:0] out_val_reg;
    logic               out_last_reg;

    assign rows_eff = clamp_grid(cfg.grid_rows, MAX_GRID);
    assign cols_eff = cfg.mode_two_dim ? clamp_grid(cfg.grid_cols, MAX_GRID) : 11'd1;
    assign col_in   = cfg.mode_two_dim ? point_col : 10'd0;

    assign row_prod   = 21'(point_row) * 21'(cols_eff);
    assign row_flat_n = 22'(row_prod) + 22'(col_in);

    assign adv = !out_valid_reg || out_ready;

    assign status.adv        = adv;
    assign status.point_ok   = ({1'b0, point_row} < rows_eff) && ({1'b0, col_in} < cols_eff);
    assign status.flush_done = adv && c_valid_reg && c_flush_reg;

    // Coefficient store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.load_coeff && (int'(coeff_slot) < DEPTH))
            store_mem[SLOT_W'(coeff_slot)] <= coeff_value;
        if (cmd.issue)
            rd_reg <= store_mem[SLOT_W'(cmd.slot)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            row_reg      <= point_row;
            col_reg      <= col_in;
            pot_reg      <= potential;
            row_flat_reg <= row_flat_n[19:0];
        end
    end

    // Neighbour coordinates and grid bounds
    assign ri_n  = 12'(row_reg) + 12'(cmd.dx);
    assign ci_n  = 12'(col_reg) + 12'(cmd.dy);
    assign inb_n = !ri_n[11] && (ri_n[10:0] < rows_eff) &&
                   !ci_n[11] && (ci_n[10:0] < cols_eff);

    assign coeff_b    = signed'(rd_reg);
    assign mag_b      = rd_reg[31] ? (32'd0 - rd_reg) : rd_reg;
    assign big_b      = mag_b > {1'b0, cfg.coeff_threshold};
    assign prod_b     = coeff_b * cfg.ekin_scale;
    assign col_flat_b = 23'(a_ri_reg) * 23'(cols_eff) + 23'(a_ci_reg);

    // Round to nearest, ties up, then scale down by 2^16 or 2^17
    assign rnd_c     = b_prod_reg + (cfg.mode_two_dim ? 64'sd65536 : 64'sd32768);
    assign sh_full_c = cfg.mode_two_dim ? (rnd_c >>> 17) : (rnd_c >>> 16);

    assign sum_d = 49'(c_sh_reg) + (c_diag_reg ? 49'(pot_reg) : 49'sd0);

    always_comb
    begin
        if (sum_d > 49'(SAT_MAX))
            cand_d = SAT_MAX;
        else if (sum_d < 49'(SAT_MIN))
            cand_d = SAT_MIN;
        else
            cand_d = sum_d[31:0];
    end

    // Control state of the pipeline and output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                a_valid_reg <= cmd.issue || cmd.flush;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                if (c_valid_reg && c_flush_reg)
                begin
                    out_valid_reg  <= pend_valid_reg;
                    pend_valid_reg <= 1'b0;
                end
                else if (c_valid_reg && c_keep_reg)
                begin
                    out_valid_reg  <= pend_valid_reg;
                    pend_valid_reg <= 1'b1;
                end
                else if (out_ready)
                    out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the pipeline and output
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_flush_reg <= cmd.flush;
            a_inb_reg   <= inb_n;
            a_diag_reg  <= cmd.diag;
            a_ri_reg    <= ri_n[10:0];
            a_ci_reg    <= ci_n[10:0];

            b_flush_reg <= a_flush_reg;
            b_keep_reg  <= a_inb_reg && (big_b || a_diag_reg);
            b_use_reg   <= big_b;
            b_diag_reg  <= a_diag_reg;
            b_prod_reg  <= prod_b;
            b_cf_reg    <= col_flat_b[19:0];

            c_flush_reg <= b_flush_reg;
            c_keep_reg  <= b_keep_reg;
            c_diag_reg  <= b_diag_reg;
            c_sh_reg    <= b_use_reg ? sh_full_c[47:0] : 48'sd0;
            c_cf_reg    <= b_cf_reg;

            if (c_valid_reg && (c_flush_reg || c_keep_reg))
            begin
                out_row_reg  <= pend_row_reg;
                out_col_reg  <= pend_cf_reg;
                out_val_reg  <= pend_val_reg;
                out_last_reg <= c_flush_reg;
            end
            if (c_valid_reg && !c_flush_reg && c_keep_reg)
            begin
                pend_row_reg <= row_flat_reg;
                pend_cf_reg  <= c_cf_reg;
                pend_val_reg <= cand_d;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign matrix_row    = out_row_reg;
    assign matrix_col    = out_col_reg;
    assign entry_value   = out_val_reg;
    assign last_of_point = out_last_reg;

endmodule

/* design/stencil_matrix_triplet_generator_unit.sv */
// Top level: stencil matrix triplet generator with configuration registers.
//
// Turns finite-difference stencil coefficients into sparse-matrix triplets, one
// grid point at a time. A load transaction (req_type 0) writes one coefficient into
// the stencil store and leaves the block idle; a slot beyond the store is dropped.
// A point transaction (req_type 1) walks the stencil offsets, first axis outer and
// second axis inner, and emits one triplet (flat row, flat column, Q16.16 value)
// per kept offset; the diagonal always appears, carries the potential, and the
// final triplet of a point has last_of_point set. A point outside the grid gives
// no triplet and finishes at once. The offset sequencer issues one offset per
// cycle while the triplet channel does not stall, into a four-stage pipeline
// (store read, 32x32 multiply, rounding, potential add with saturation), and the
// next request is taken once the end-of-point marker leaves that pipeline. The
// triplet output register lets the next request in while the last triplet still
// waits. Entries of the stencil store hold nothing until written; write every
// slot the stencil uses before the first point. Configuration registers must be
// written only while the block is idle; the block itself does not enforce this.
module stencil_matrix_triplet_generator_unit
    import smtg_pkg::*;
#(
    parameter int MAX_STENCIL = 5,
    parameter int MAX_GRID    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    smtg_req_if.sink    req,
    smtg_trip_if.source trip
);

    cfg_t       cfg_reg;
    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       req_ready;

    // Configuration register bank; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_two_dim    <= 1'b1;
            cfg_reg.grid_rows       <= 11'd64;
            cfg_reg.grid_cols       <= 11'd64;
            cfg_reg.stencil_width   <= 3'd5;
            cfg_reg.ekin_scale      <= 32'sd65536;
            cfg_reg.coeff_threshold <= 31'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE_TWO_DIM:    cfg_reg.mode_two_dim    <= cfg_wdata[0];
                CFG_GRID_ROWS:       cfg_reg.grid_rows       <= cfg_wdata[10:0];
                CFG_GRID_COLS:       cfg_reg.grid_cols       <= cfg_wdata[10:0];
                CFG_STENCIL_WIDTH:   cfg_reg.stencil_width   <= cfg_wdata[2:0];
                CFG_EKIN_SCALE:      cfg_reg.ekin_scale      <= cfg_wdata;
                CFG_COEFF_THRESHOLD: cfg_reg.coeff_threshold <= cfg_wdata[30:0];
                default:             ;
            endcase
        end
    end

    // Sequence requests and step through the offsets
    smtg_ctrl #(
        .MAX_STENCIL(MAX_STENCIL)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Store, arithmetic pipeline and triplet output register
    smtg_dp #(
        .MAX_STENCIL(MAX_STENCIL),
        .MAX_GRID   (MAX_GRID)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .status        (status),
        .coeff_slot    (req.coeff_slot),
        .coeff_value   (req.coeff_value),
        .point_row     (req.point_row),
        .point_col     (req.point_col),
        .potential     (req.potential),
        .out_valid     (trip.valid),
        .out_ready     (trip.ready),
        .matrix_row    (trip.matrix_row),
        .matrix_col    (trip.matrix_col),
        .entry_value   (trip.entry_value),
        .last_of_point (trip.last_of_point)
    );

    assign req.ready = req_ready;

    // A point inside the grid holds off further requests once it is taken
    a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.req_type == REQ_POINT) && status.point_ok
        |=> !req.ready)
        else $error("request taken while a point walk is under way");

    // A coefficient load stays idle and produces nothing
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.req_type == REQ_LOAD) |=> req.ready)
        else $error("coefficient load left the block busy");

    // Offsets enter the pipeline only when it can advance
    a_issue_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.flush) |-> status.adv)
        else $error("offset issued into a stalled pipeline");

    // The end-of-point marker only completes while a point is in flight
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.flush_done |-> !req.ready)
        else $error("end-of-point marker seen while idle");

endmodule

/* test/smtg_tb_pkg.sv */
// Scoreboard and transaction types for the stencil matrix triplet generator testbench.
package smtg_tb_pkg;
    import smtg_pkg::*;

    localparam int STENCIL_MAX = 5;
    localparam int GRID_MAX    = 1024;
    localparam int STORE_SLOTS = STENCIL_MAX * STENCIL_MAX;
    localparam int REPORT_MAX  = 10;

    localparam longint ENTRY_MAX = 64'sd2147483647;
    localparam longint ENTRY_MIN = -64'sd2147483648;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  coeff_slot;
        logic [31:0] coeff_value;
        logic [9:0]  point_row;
        logic [9:0]  point_col;
        logic [31:0] potential;
    } stencil_request_t;

    typedef struct packed {
        logic [19:0] matrix_row;
        logic [19:0] matrix_col;
        logic [31:0] entry_value;
        logic        last_of_point;
    } triplet_t;

    // Grid extent as the block sees it: zero counts as one, oversize saturates
    function automatic int grid_extent(bit [10:0] g);
        if (g == 0)
            return 1;
        if (g > GRID_MAX)
            return GRID_MAX;
        return int'(g);
    endfunction

    class triplet_scoreboard;
        bit          two_dim;
        bit [10:0]   rows_reg;
        bit [10:0]   cols_reg;
        bit [2:0]    width_reg;
        bit [31:0]   scale_reg;
        bit [30:0]   thresh_reg;
        bit [31:0]   coeff_store [STORE_SLOTS];
        triplet_t    expected_triplets[$];
        int          mismatches;

        function new();
            two_dim    = 1'b1;
            rows_reg   = 11'd64;
            cols_reg   = 11'd64;
            width_reg  = 3'd5;
            scale_reg  = 32'h0001_0000;
            thresh_reg = 31'd0;
            mismatches = 0;
        endfunction

        function void write_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_MODE_TWO_DIM:    two_dim    = data[0];
                CFG_GRID_ROWS:       rows_reg   = data[10:0];
                CFG_GRID_COLS:       cols_reg   = data[10:0];
                CFG_STENCIL_WIDTH:   width_reg  = data[2:0];
                CFG_EKIN_SCALE:      scale_reg  = data;
                CFG_COEFF_THRESHOLD: thresh_reg = data[30:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_triplets.size();
        endfunction

        // Note an accepted request: store a coefficient or expand a point into triplets
        function void note_request(stencil_request_t rq);
            longint   rows, cols, r, c, w, h, yh, xs, ys, ri, ci, slot;
            longint   coeff, mag, thr, scale, pot, val;
            int       shift;
            bit       diag;
            triplet_t t;
            triplet_t point_trips[$];
            if (rq.req_type == REQ_LOAD)
            begin
                if (rq.coeff_slot < STORE_SLOTS)
                    coeff_store[rq.coeff_slot] = rq.coeff_value;
                return;
            end
            rows = grid_extent(rows_reg);
            cols = two_dim ? grid_extent(cols_reg) : 1;
            r = rq.point_row;
            c = two_dim ? rq.point_col : 0;
            if (r >= rows || c >= cols)
                return;
            w = width_reg;
            if (w < 1)
                w = 1;
            if (w > STENCIL_MAX)
                w = STENCIL_MAX;
            if (w % 2 == 0)
                w = w - 1;
            h = w / 2;
            yh = two_dim ? h : 0;
            thr = thresh_reg;
            scale = longint'($signed(scale_reg));
            pot = longint'($signed(rq.potential));
            shift = two_dim ? 17 : 16;
            for (xs = -h; xs <= h; xs++)
            begin
                ri = r + xs;
                if (ri < 0 || ri >= rows)
                    continue;
                for (ys = -yh; ys <= yh; ys++)
                begin
                    ci = c + ys;
                    if (ci < 0 || ci >= cols)
                        continue;
                    slot = two_dim ? (xs + h) * w + (ys + h) : xs + h;
                    coeff = longint'($signed(coeff_store[int'(slot)]));
                    mag = (coeff < 0) ? -coeff : coeff;
                    diag = (xs == 0 && ys == 0);
                    if (!(mag > thr) && !diag)
                        continue;
                    val = 0;
                    if (mag > thr)
                        val = (coeff * scale + (longint'(1) <<< (shift - 1))) >>> shift;
                    if (diag)
                        val = val + pot;
                    if (val > ENTRY_MAX)
                        val = ENTRY_MAX;
                    else if (val < ENTRY_MIN)
                        val = ENTRY_MIN;
                    t.matrix_row    = 20'(r * cols + c);
                    t.matrix_col    = 20'(ri * cols + ci);
                    t.entry_value   = val[31:0];
                    t.last_of_point = 1'b0;
                    point_trips.push_back(t);
                end
            end
            foreach (point_trips[k])
            begin
                t = point_trips[k];
                t.last_of_point = (k == point_trips.size() - 1);
                expected_triplets.push_back(t);
            end
        endfunction

        // Compare one accepted triplet against the oldest expectation
        function void check_triplet(triplet_t got);
            triplet_t want;
            if (expected_triplets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected triplet: row %0d col %0d value %h last %0b",
                             got.matrix_row, got.matrix_col, got.entry_value,
                             got.last_of_point);
                return;
            end
            want = expected_triplets.pop_front();
            if (got.matrix_row !== want.matrix_row || got.matrix_col !== want.matrix_col ||
                got.entry_value !== want.entry_value ||
                got.last_of_point !== want.last_of_point)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("triplet mismatch: expected row %0d col %0d value %h last %0b, %s",
                             want.matrix_row, want.matrix_col, want.entry_value,
                             want.last_of_point,
                             $sformatf("got row %0d col %0d value %h last %0b",
                                       got.matrix_row, got.matrix_col, got.entry_value,
                                       got.last_of_point));
            end
        endfunction
    endclass

endpackage

/* test/stencil_matrix_triplet_generator_unit_tb.sv */
// Top-level testbench: drives requests and configuration, checks every emitted triplet.
module stencil_matrix_triplet_generator_unit_tb;
    import smtg_pkg::*;
    import smtg_tb_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    // Settle time after draining: room for a point in flight to leave the block
    localparam int SETTLE_CYCLES = 64;
    // Longest quiet stretch: the long output hold plus a full point and gaps
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 120;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    smtg_req_if  req ();
    smtg_trip_if trip ();

    triplet_scoreboard sb;

    // Idling on both channels; cleared for the final stretch of the run
    bit idling_on;

    // Effective grid of the current setting, used to keep most points inside it
    bit cur_two;
    int cur_rows;
    int cur_cols;

    stencil_matrix_triplet_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .trip      (trip)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Random request; every field is filled whatever the type so all bits toggle
    function automatic stencil_request_t random_request();
        stencil_request_t rq;
        rq.req_type   = ($urandom_range(0, 3) == 0) ? REQ_LOAD : REQ_POINT;
        rq.coeff_slot = $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 0)
            rq.coeff_value = $urandom;
        else
            rq.coeff_value = $urandom_range(0, 32'h3ffff) - 32'h20000;
        // Mostly inside the grid; the odd one anywhere in the field's range
        if ($urandom_range(0, 6) == 0)
            rq.point_row = $urandom_range(0, 1023);
        else
            rq.point_row = $urandom_range(0, cur_rows - 1);
        if (!cur_two || $urandom_range(0, 6) == 0)
            rq.point_col = $urandom_range(0, 1023);
        else
            rq.point_col = $urandom_range(0, cur_cols - 1);
        if ($urandom_range(0, 1) == 0)
            rq.potential = $urandom;
        else
            rq.potential = $urandom_range(0, 32'h7ffff) - 32'h40000;
        return rq;
    endfunction

    function automatic stencil_request_t load_request(input bit [4:0] slot,
                                                      input bit [31:0] value);
        stencil_request_t rq;
        rq = random_request();
        rq.req_type    = REQ_LOAD;
        rq.coeff_slot  = slot;
        rq.coeff_value = value;
        return rq;
    endfunction

    function automatic stencil_request_t point_request(input bit [9:0] row,
                                                       input bit [9:0] col,
                                                       input bit [31:0] pot);
        stencil_request_t rq;
        rq = random_request();
        rq.req_type  = REQ_POINT;
        rq.point_row = row;
        rq.point_col = col;
        rq.potential = pot;
        return rq;
    endfunction

    // Offer one request, optionally after an idle burst, and hold it until accepted.
    // Entered and left at a rising edge; valid is assigned once per edge.
    task automatic send_request(input stencil_request_t rq);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.req_type    <= rq.req_type;
        req.coeff_slot  <= rq.coeff_slot;
        req.coeff_value <= rq.coeff_value;
        req.point_row   <= rq.point_row;
        req.point_col   <= rq.point_col;
        req.potential   <= rq.potential;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    // Drop valid, wait for every expected triplet, then let loads and points
    // that produce nothing work their way out of the pipeline
    task automatic drain_block();
        req.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_register(idx, data);
    endtask

    // Move to a new setting; registers only change with the block idle
    task automatic apply_setting(input bit two, input bit [10:0] rows, input bit [10:0] cols,
                                 input bit [2:0] width, input bit [31:0] scale,
                                 input bit [30:0] thresh);
        drain_block();
        write_register(CFG_MODE_TWO_DIM, {31'd0, two});
        write_register(CFG_GRID_ROWS, {21'd0, rows});
        write_register(CFG_GRID_COLS, {21'd0, cols});
        write_register(CFG_STENCIL_WIDTH, {29'd0, width});
        write_register(CFG_EKIN_SCALE, scale);
        write_register(CFG_COEFF_THRESHOLD, {1'b0, thresh});
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_two  = two;
        cur_rows = grid_extent(rows);
        cur_cols = two ? grid_extent(cols) : 1;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Directed part under the reset setting: 2D, 64 x 64, width 5, unit scale
    task automatic run_directed();
        // Fill the whole store first; extremes at the corner and centre slots
        for (int k = 0; k < STORE_SLOTS; k++)
            send_request(load_request(5'(k),
                (k == 0)      ? 32'h7fff_ffff :
                (k == 12)     ? 32'h8000_0000 :
                (k % 4 == 1)  ? 32'h0 : 32'((k - 12) * 16384 + k)));
        // Slots beyond the store: the write is dropped
        send_request(load_request(5'd31, 32'hdead_beef));
        send_request(load_request(5'd25, 32'h1234_5678));
        // Corners, centre and edges, potentials at the extremes
        send_request(point_request(10'd0, 10'd0, 32'h0));
        send_request(point_request(10'd63, 10'd63, 32'h7fff_ffff));
        send_request(point_request(10'd32, 10'd32, 32'h8000_0000));
        send_request(point_request(10'd1, 10'd62, 32'h0001_8000));
        // Points outside the grid give nothing
        send_request(point_request(10'd64, 10'd0, 32'h1));
        send_request(point_request(10'd0, 10'd64, 32'h1));
        send_request(point_request(10'd1023, 10'd1023, 32'h0));
        // Diagonal coefficient at zero: the diagonal still appears, holding the potential
        send_request(load_request(5'd12, 32'h0));
        send_request(point_request(10'd5, 10'd5, 32'h1234_5678));
        send_request(load_request(5'd12, 32'h0002_0000));
        send_request(point_request(10'd63, 10'd0, 32'hfffe_0000));
    endtask

    // Triplet sink: check each transaction, vary ready in bursts, and once
    // choke the output for a long stretch so the block backs up into its input
    initial
    begin : triplet_sink
        int       left;
        int       taken;
        bit       held_long;
        triplet_t got;
        left      = 0;
        taken     = 0;
        held_long = 1'b0;
        trip.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (trip.valid && trip.ready)
            begin
                got.matrix_row    = trip.matrix_row;
                got.matrix_col    = trip.matrix_col;
                got.entry_value   = trip.entry_value;
                got.last_of_point = trip.last_of_point;
                sb.check_triplet(got);
                taken++;
            end
            if (left > 0)
                left--;
            else if (!held_long && taken >= HOLD_AFTER)
            begin
                held_long = 1'b1;
                trip.ready <= 1'b0;
                left = LONG_HOLD - 1;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                trip.ready <= 1'b0;
                left = $urandom_range(1, 13) - 1;
            end
            else
            begin
                trip.ready <= 1'b1;
                left = $urandom_range(1, 16) - 1;
            end
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (trip.valid && trip.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stencil_matrix_triplet_generator_unit verification failed");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        idling_on = 1'b1;
        cur_two   = 1'b1;
        cur_rows  = 64;
        cur_cols  = 64;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_MODE_TWO_DIM;
        cfg_wdata       <= 32'd0;
        req.valid       <= 1'b0;
        req.req_type    <= REQ_LOAD;
        req.coeff_slot  <= 5'd0;
        req.coeff_value <= 32'd0;
        req.point_row   <= 10'd0;
        req.point_col   <= 10'd0;
        req.potential   <= 32'd0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting untouched for the directed part
        run_directed();

        // Largest grid, largest positive scale: products saturate
        apply_setting(1'b1, 11'd1024, 11'd1024, 3'd5, 32'h7fff_ffff, 31'd0);
        run_random(10);

        // 1D, width 7 clamps to 5, most negative scale, threshold at its top
        apply_setting(1'b0, 11'd1024, 11'd0, 3'd7, 32'h8000_0000, 31'h7fff_ffff);
        run_random(10);

        // Zero rows counts as one, oversize columns saturate, even width drops to 3
        apply_setting(1'b1, 11'd0, 11'd2047, 3'd4, $urandom, 31'h0001_0000);
        run_random(10);

        // 1D single point grid, width zero counts as one, negative unit scale
        apply_setting(1'b0, 11'd1, 11'd1, 3'd0, 32'hffff_0000, 31'd0);
        run_random(8);

        // Small 2D grid, half scale, random threshold
        apply_setting(1'b1, 11'd8, 11'd8, 3'd3, 32'h0000_8000, $urandom_range(0, 32'h1ffff));
        run_random(12);

        // Final stretch at full rate on both sides; width 6 narrows to 5
        apply_setting(1'b1, 11'd64, 11'd64, 3'd6, 32'h0001_0000, 31'd0);
        idling_on = 1'b0;
        run_random(22);

        drain_block();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("stencil_matrix_triplet_generator_unit verification clean");
        else
            $display("stencil_matrix_triplet_generator_unit verification failed");
        $finish;
    end

endmodule

/* stencil_matrix_triplet_generator_unit.f */
design/smtg_pkg.sv
design/smtg_if.sv
design/smtg_ctrl.sv
design/smtg_dp.sv
design/stencil_matrix_triplet_generator_unit.sv
test/smtg_tb_pkg.sv
test/stencil_matrix_triplet_generator_unit_tb.sv
